FILE: sv/pirs_pkg.sv
// ----------------------------------------------------------------------------
// pirs_pkg
// Shared widths, codes and types for the point-in-rectangle set checker.
// ----------------------------------------------------------------------------
package pirs_pkg;

   localparam int COORD_W  = 16;
   localparam int MAX_RECT = 64;
   localparam int IDX_W    = (MAX_RECT > 1) ? $clog2(MAX_RECT) : 1;
   localparam int CNT_W    = $clog2(MAX_RECT + 1);
   localparam int ENTRY_W  = 7;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int SUM_W    = PROD_W + 1;

   localparam logic [1:0] MODE_CLEAR = 2'd0;
   localparam logic [1:0] MODE_LOAD  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef struct packed {
      coord_type a_x;
      coord_type a_y;
      coord_type b_x;
      coord_type b_y;
      coord_type d_x;
      coord_type d_y;
   } rect_type;

   typedef struct packed {
      logic mul_en;
      logic first;
   } mul_ctl_type;

endpackage

FILE: sv/pirs_dot_unit.sv
// ----------------------------------------------------------------------------
// pirs_dot_unit
// Shared multiplier and accumulator; sums pairs of products into dot products.
// ----------------------------------------------------------------------------
module pirs_dot_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  pirs_pkg::mul_ctl_type ctl,
   input  pirs_pkg::diff_type   op_a,
   input  pirs_pkg::diff_type   op_b,
   output pirs_pkg::sum_type    dot_sum
);
   import pirs_pkg::*;

   prod_type prod_ff, prod_in;
   logic     p_en_ff, p_en_in;
   logic     p_first_ff, p_first_in;
   sum_type  acc_ff, acc_in;

   always_comb begin
      prod_in    = prod_type'(op_a) * prod_type'(op_b);
      p_en_in    = ctl.mul_en;
      p_first_in = ctl.first;
      acc_in     = acc_ff;
      if (p_en_ff) begin
         if (p_first_ff) begin
            acc_in = SUM_W'(prod_ff);
         end else begin
            acc_in = acc_ff + SUM_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_en_ff    <= 1'b0;
         p_first_ff <= 1'b0;
      end else begin
         p_en_ff    <= p_en_in;
         p_first_ff <= p_first_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign dot_sum = acc_ff;

endmodule

FILE: sv/point_in_rectangle_set_check.sv
// ----------------------------------------------------------------------------
// point_in_rectangle_set_check
// Table of rectangles with clear, load and strict point-inside query.
// ----------------------------------------------------------------------------
// clear, load and unused mode: the item goes from idle straight to the done state, then to the output register
// query: walks the stored rectangles in order (read, diff, multiply states), stopping at the first hit
//   or after the last entry; one shared multiplier does 8 products per entry
// one item at a time: req_ready is low from accept until the result enters the output register
// reset empties the table and drops any pending result; no clearing pass
module point_in_rectangle_set_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_mode,
   input  pirs_pkg::coord_type       req_corner_a_x,
   input  pirs_pkg::coord_type       req_corner_a_y,
   input  pirs_pkg::coord_type       req_corner_b_x,
   input  pirs_pkg::coord_type       req_corner_b_y,
   input  pirs_pkg::coord_type       req_corner_d_x,
   input  pirs_pkg::coord_type       req_corner_d_y,
   input  pirs_pkg::coord_type       req_point_x,
   input  pirs_pkg::coord_type       req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_inside_res,
   output logic                      rsp_status,
   output logic [pirs_pkg::ENTRY_W-1:0] rsp_entries_used
);
   import pirs_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_DIFF = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [3:0] STEP_AB2  = 4'd3;
   localparam logic [3:0] STEP_AD2  = 4'd5;
   localparam logic [3:0] STEP_AMAB = 4'd7;
   localparam logic [3:0] STEP_LAST = 4'd9;

   rect_type rect_mem [MAX_RECT];
   rect_type rd_data_ff;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [3:0]       step_ff, step_in;
   coord_type        point_x_ff, point_x_in;
   coord_type        point_y_ff, point_y_in;
   diff_type         abx_ff, abx_in, aby_ff, aby_in;
   diff_type         adx_ff, adx_in, ady_ff, ady_in;
   diff_type         amx_ff, amx_in, amy_ff, amy_in;
   sum_type          ab2_ff, ab2_in, ad2_ff, ad2_in, amab_ff, amab_in;
   logic             res_inside_ff, res_inside_in;
   logic             res_status_ff, res_status_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inside_ff, rsp_inside_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [ENTRY_W-1:0] rsp_entries_ff, rsp_entries_in;

   logic        req_fire;
   logic        mem_we;
   rect_type    mem_wdata;
   logic        last_entry;
   logic        hit;
   mul_ctl_type mul_ctl;
   diff_type    op_a, op_b;
   sum_type     dot_sum;

   pirs_dot_unit u_dot (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mul_ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .dot_sum (dot_sum)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   assign mem_wdata.a_x = req_corner_a_x;
   assign mem_wdata.a_y = req_corner_a_y;
   assign mem_wdata.b_x = req_corner_b_x;
   assign mem_wdata.b_y = req_corner_b_y;
   assign mem_wdata.d_x = req_corner_d_x;
   assign mem_wdata.d_y = req_corner_d_y;
   assign mem_we = req_fire && (req_mode == MODE_LOAD) && (count_ff < CNT_W'(MAX_RECT));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         rect_mem[count_ff[IDX_W-1:0]] <= mem_wdata;
      end
      rd_data_ff <= rect_mem[idx_ff];
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_ctl.mul_en = (state_ff == ST_MUL) && !step_ff[3];
      mul_ctl.first  = !step_ff[0];
      case (step_ff[2:0])
         3'd0:    begin op_a = abx_ff; op_b = abx_ff; end
         3'd1:    begin op_a = aby_ff; op_b = aby_ff; end
         3'd2:    begin op_a = adx_ff; op_b = adx_ff; end
         3'd3:    begin op_a = ady_ff; op_b = ady_ff; end
         3'd4:    begin op_a = amx_ff; op_b = abx_ff; end
         3'd5:    begin op_a = amy_ff; op_b = aby_ff; end
         3'd6:    begin op_a = amx_ff; op_b = adx_ff; end
         default: begin op_a = amy_ff; op_b = ady_ff; end
      endcase
   end

   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign hit = (amab_ff > 0) && (amab_ff < ab2_ff) && (dot_sum > 0) && (dot_sum < ad2_ff);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      step_in        = step_ff;
      point_x_in     = point_x_ff;
      point_y_in     = point_y_ff;
      abx_in         = abx_ff;
      aby_in         = aby_ff;
      adx_in         = adx_ff;
      ady_in         = ady_ff;
      amx_in         = amx_ff;
      amy_in         = amy_ff;
      ab2_in         = ab2_ff;
      ad2_in         = ad2_ff;
      amab_in        = amab_ff;
      res_inside_in  = res_inside_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_inside_in  = rsp_inside_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_entries_in = rsp_entries_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               res_inside_in = 1'b0;
               res_status_in = 1'b0;
               state_in      = ST_DONE;
               case (req_mode)
                  MODE_CLEAR: begin
                     count_in = '0;
                  end
                  MODE_LOAD: begin
                     if (count_ff < CNT_W'(MAX_RECT)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = 1'b1;
                     end
                  end
                  MODE_QUERY: begin
                     point_x_in = req_point_x;
                     point_y_in = req_point_y;
                     idx_in     = '0;
                     if (count_ff != '0) begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     count_in = count_ff;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            abx_in   = DIFF_W'(rd_data_ff.b_x) - DIFF_W'(rd_data_ff.a_x);
            aby_in   = DIFF_W'(rd_data_ff.b_y) - DIFF_W'(rd_data_ff.a_y);
            adx_in   = DIFF_W'(rd_data_ff.d_x) - DIFF_W'(rd_data_ff.a_x);
            ady_in   = DIFF_W'(rd_data_ff.d_y) - DIFF_W'(rd_data_ff.a_y);
            amx_in   = DIFF_W'(point_x_ff) - DIFF_W'(rd_data_ff.a_x);
            amy_in   = DIFF_W'(point_y_ff) - DIFF_W'(rd_data_ff.a_y);
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            step_in = step_ff + 4'd1;
            if (step_ff == STEP_AB2) begin
               ab2_in = dot_sum;
            end
            if (step_ff == STEP_AD2) begin
               ad2_in = dot_sum;
            end
            if (step_ff == STEP_AMAB) begin
               amab_in = dot_sum;
            end
            if (step_ff == STEP_LAST) begin
               if (hit) begin
                  res_inside_in = 1'b1;
                  state_in      = ST_DONE;
               end else if (last_entry) begin
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_inside_in  = res_inside_ff;
               rsp_status_in  = res_status_ff;
               rsp_entries_in = ENTRY_W'(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      point_x_ff     <= point_x_in;
      point_y_ff     <= point_y_in;
      abx_ff         <= abx_in;
      aby_ff         <= aby_in;
      adx_ff         <= adx_in;
      ady_ff         <= ady_in;
      amx_ff         <= amx_in;
      amy_ff         <= amy_in;
      ab2_ff         <= ab2_in;
      ad2_ff         <= ad2_in;
      amab_ff        <= amab_in;
      res_inside_ff  <= res_inside_in;
      res_status_ff  <= res_status_in;
      rsp_inside_ff  <= rsp_inside_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_entries_ff <= rsp_entries_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_inside_res   = rsp_inside_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entries_used = rsp_entries_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RECT))
      else $error("entry count beyond table depth");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item taken while previous item still in progress");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside of completion");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_inside_ff && rsp_status_ff))
      else $error("inside and full flags both set");

   a_query_index_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (CNT_W'(idx_ff) < count_ff))
      else $error("query walks past stored entries");

endmodule
